[hw/rtl/ofgm_pkg.sv]
// Shared types and constants of the gravity/magnetometer orientation block.
// Holds the front-to-back item type and the arctangent step table.
// No dependencies.
package ofgm_pkg;

	localparam int SW           = 16;
	localparam int CORDIC_STEPS = 22;
	localparam int MAG_W        = 64;
	localparam int CW           = 34;
	localparam int Z_W          = 25;
	localparam int ANG_W        = 16;
	localparam int ANG_FRAC     = 8;
	localparam int Z_MAX        = 2304000;
	localparam int ANG_HALF     = 18000;
	localparam int ANG_FULL     = 36000;
	localparam int NORM_TOP     = 34;
	localparam int ISQ_IN_W     = 62;
	localparam int QDEPTH       = 4;
	localparam int CFG_W        = 32;

	typedef struct packed {
		logic               ok;
		logic signed [32:0] hy;
		logic signed [49:0] my;
		logic [31:0]        asq;
		logic [31:0]        axz;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} item_t;

	function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] idx);
		case (idx)
			5'd0: return 25'sd1152000;
			5'd1: return 25'sd680065;
			5'd2: return 25'sd359328;
			5'd3: return 25'sd182400;
			5'd4: return 25'sd91554;
			5'd5: return 25'sd45822;
			5'd6: return 25'sd22916;
			5'd7: return 25'sd11459;
			5'd8: return 25'sd5730;
			5'd9: return 25'sd2865;
			5'd10: return 25'sd1432;
			5'd11: return 25'sd716;
			5'd12: return 25'sd358;
			5'd13: return 25'sd179;
			5'd14: return 25'sd90;
			5'd15: return 25'sd45;
			5'd16: return 25'sd22;
			5'd17: return 25'sd11;
			5'd18: return 25'sd6;
			5'd19: return 25'sd3;
			5'd20: return 25'sd1;
			5'd21: return 25'sd1;
			default: return '0;
		endcase
	endfunction

endpackage

[hw/rtl/ofgm_front.sv]
// Front pipeline: sample reduction, cross products, magnitude checks.
// Classifies each item as valid or not against the threshold register.
// Depends on ofgm_pkg.
module ofgm_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [6*16-1:0]      in_data,
	input  logic                 cfg_valid,
	input  logic [31:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_full,
	output ofgm_pkg::item_t      out_item
);
	import ofgm_pkg::*;

	localparam int RSH = (SAMPLE_BITS > SW) ? SAMPLE_BITS - SW : 0;
	localparam int LSH = (SAMPLE_BITS < SW) ? SW - SAMPLE_BITS : 0;
	localparam int SH  = 4 * RSH;

	logic en;
	logic [SW-1:0] raw_w;
	logic signed [SW-1:0] tmp_w;
	logic signed [SW-1:0] smp_w [6];

	logic [CFG_W-1:0] cfg_q;
	logic [63:0] mn2_q, need_q, mn2_w, need_w;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [15:0] g_s1 [3], e_s1 [3];
	logic signed [31:0] p_w [6], sq_w [3];
	logic signed [31:0] p_s2 [6];
	logic [30:0] sq_s2 [3];
	logic signed [15:0] g_s2 [3], g_s3 [3], g_s4 [3], g_s5 [3];
	logic signed [32:0] h_s3 [3];
	logic [31:0] asq_s3, axz_s3, asq_s4, axz_s4, asq_s5, axz_s5;
	logic signed [65:0] hh_w [3];
	logic signed [48:0] azhx_w, axhz_w, azhx_s4, axhz_s4;
	logic [63:0] hh_s4 [3];
	logic signed [32:0] hy_s4, hy_s5;
	logic [63:0] hsq_s5;
	logic signed [49:0] my_s5;
	item_t item_s6;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			raw_w = in_data[i*SW +: SW];
			tmp_w = signed'(raw_w << LSH);
			if (SAMPLE_BITS > SW) begin
				smp_w[i] = signed'(raw_w >> RSH);
			end else begin
				smp_w[i] = tmp_w >>> LSH;
			end
		end
	end

	always_comb begin
		mn2_w  = cfg_q * cfg_q;
		need_w = (mn2_q >> SH) + 64'(|(mn2_q & ~({64{1'b1}} << SH)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= 32'd1;
			mn2_q  <= 64'd1;
			need_q <= 64'd1;
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			mn2_q  <= mn2_w;
			need_q <= need_w;
		end
	end

	always_comb begin
		en       = !(vld_s6 && out_full);
		in_ready = en;
		p_w[0]   = e_s1[1] * g_s1[2];
		p_w[1]   = e_s1[2] * g_s1[1];
		p_w[2]   = e_s1[2] * g_s1[0];
		p_w[3]   = e_s1[0] * g_s1[2];
		p_w[4]   = e_s1[0] * g_s1[1];
		p_w[5]   = e_s1[1] * g_s1[0];
		for (int i = 0; i < 3; i++) begin
			sq_w[i] = g_s1[i] * g_s1[i];
			hh_w[i] = h_s3[i] * h_s3[i];
		end
		azhx_w = g_s3[2] * h_s3[0];
		axhz_w = g_s3[0] * h_s3[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				g_s1[i]  <= smp_w[i];
				e_s1[i]  <= smp_w[i+3];
				sq_s2[i] <= sq_w[i][30:0];
				g_s2[i]  <= g_s1[i];
				g_s3[i]  <= g_s2[i];
				hh_s4[i] <= hh_w[i][63:0];
				g_s4[i]  <= g_s3[i];
				g_s5[i]  <= g_s4[i];
			end
			for (int i = 0; i < 6; i++) begin
				p_s2[i] <= p_w[i];
			end
			h_s3[0] <= 33'(p_s2[0]) - 33'(p_s2[1]);
			h_s3[1] <= 33'(p_s2[2]) - 33'(p_s2[3]);
			h_s3[2] <= 33'(p_s2[4]) - 33'(p_s2[5]);
			asq_s3  <= 32'(sq_s2[0]) + 32'(sq_s2[1]) + 32'(sq_s2[2]);
			axz_s3  <= 32'(sq_s2[0]) + 32'(sq_s2[2]);
			azhx_s4 <= azhx_w;
			axhz_s4 <= axhz_w;
			hy_s4   <= h_s3[1];
			asq_s4  <= asq_s3;
			axz_s4  <= axz_s3;
			hsq_s5  <= hh_s4[0] + hh_s4[1] + hh_s4[2];
			my_s5   <= 50'(azhx_s4) - 50'(axhz_s4);
			hy_s5   <= hy_s4;
			asq_s5  <= asq_s4;
			axz_s5  <= axz_s4;
			item_s6.ok  <= (asq_s5 != 32'd0) && (hsq_s5 >= need_q);
			item_s6.hy  <= hy_s5;
			item_s6.my  <= my_s5;
			item_s6.asq <= asq_s5;
			item_s6.axz <= axz_s5;
			item_s6.ax  <= g_s5[0];
			item_s6.ay  <= g_s5[1];
			item_s6.az  <= g_s5[2];
		end
	end

	assign out_valid = vld_s6;
	assign out_item  = item_s6;

endmodule

[hw/rtl/ofgm_queue.sv]
// Short queue between the front and back pipelines.
// Depends on ofgm_pkg for the item type and depth.
module ofgm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_full,
	input  ofgm_pkg::item_t push_item,
	input  logic            pop,
	output logic            head_valid,
	output ofgm_pkg::item_t head_item
);
	import ofgm_pkg::*;

	localparam int QA = $clog2(QDEPTH);

	item_t mem_q [QDEPTH];
	logic [QA-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA:0] count_q;
	logic push_do, pop_do;

	always_comb begin
		push_full  = (count_q == (QA+1)'(QDEPTH));
		head_valid = (count_q != '0);
		head_item  = mem_q[rd_ptr_q];
		push_do    = push_valid && !push_full;
		pop_do     = pop && head_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_do) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_do) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_do && !pop_do) begin
				count_q <= count_q + 1'b1;
			end else if (pop_do && !push_do) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_do) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[hw/rtl/ofgm_isqrt.sv]
// Pipelined integer square root, one root bit per stage, floor result.
// Carries a sideband word in step with the data. Depends on ofgm_pkg.
module ofgm_isqrt #(
	parameter int IN_W   = 62,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [IN_W-1:0]     in_val,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_vld,
	output logic [IN_W/2-1:0]   out_root,
	output logic [SIDE_W-1:0]   out_side
);
	import ofgm_pkg::*;

	localparam int RW    = IN_W / 2;
	localparam int REM_W = RW + 3;

	logic [REM_W-1:0] rem_s [RW], src_rem [RW], rem_n [RW], remx_w [RW], trial_w [RW];
	logic [RW-1:0] root_s [RW], src_root [RW], root_n [RW];
	logic [IN_W-1:0] val_s [RW], src_val [RW];
	logic [SIDE_W-1:0] side_s [RW];
	logic [RW-1:0] vld_s;

	always_comb begin
		src_rem[0]  = '0;
		src_root[0] = '0;
		src_val[0]  = in_val;
		for (int s = 1; s < RW; s++) begin
			src_rem[s]  = rem_s[s-1];
			src_root[s] = root_s[s-1];
			src_val[s]  = val_s[s-1];
		end
		for (int s = 0; s < RW; s++) begin
			remx_w[s]  = {src_rem[s][REM_W-3:0], src_val[s][IN_W-1 -: 2]};
			trial_w[s] = REM_W'({src_root[s], 2'b01});
			if (remx_w[s] >= trial_w[s]) begin
				rem_n[s]  = remx_w[s] - trial_w[s];
				root_n[s] = {src_root[s][RW-2:0], 1'b1};
			end else begin
				rem_n[s]  = remx_w[s];
				root_n[s] = {src_root[s][RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RW-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int s = 0; s < RW; s++) begin
				rem_s[s]  <= rem_n[s];
				root_s[s] <= root_n[s];
				val_s[s]  <= src_val[s] << 2;
			end
			for (int s = 1; s < RW; s++) begin
				side_s[s] <= side_s[s-1];
			end
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign out_root = root_s[RW-1];
	assign out_side = side_s[RW-1];

endmodule

[hw/rtl/ofgm_atan.sv]
// Pipelined vectoring arctangent: normalize, 22 rotation steps, quadrant fold.
// Gives the angle in centidegrees, 0..35999. Depends on ofgm_pkg.
module ofgm_atan #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [ofgm_pkg::MAG_W-1:0]    in_y,
	input  logic                          in_ny,
	input  logic [ofgm_pkg::MAG_W-1:0]    in_x,
	input  logic                          in_nx,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_vld,
	output logic [ofgm_pkg::ANG_W-1:0]    out_ang,
	output logic [SIDE_W-1:0]             out_side
);
	import ofgm_pkg::*;

	localparam int NCH = MAG_W / 8;
	localparam int N   = CORDIC_STEPS;

	logic [MAG_W-1:0] w_w, y_s1, x_s1, y_s2, x_s2, ysh_w, xsh_w;
	logic [7:0] chunk_w;
	logic [NCH-1:0] nz_w, nz_s1;
	logic [2:0] lz_w [NCH], lz_s1 [NCH];
	logic [6:0] lzc_w, lzc_s2;
	logic [2:0] sg_s1, sg_s2, sg_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s5;
	logic zero_w;
	logic [29:0] y_s3, x_s3;

	logic signed [CW-1:0] cx_s [N], cy_s [N], sx_w [N], sy_w [N];
	logic signed [Z_W-1:0] cz_s [N], sz_w [N];
	logic [2:0] sg_s [N];
	logic [SIDE_W-1:0] cside_s [N];
	logic [N-1:0] cvld_s;
	logic vld_s1, vld_s2, vld_s3, vld_s5;

	logic signed [Z_W-1:0] zc_w, zr_w;
	logic [14:0] q_w;
	logic [16:0] a_w;
	logic [ANG_W-1:0] ang_s5;

	always_comb begin
		w_w = in_x | in_y;
		for (int c = 0; c < NCH; c++) begin
			chunk_w  = w_w[MAG_W-1-8*c -: 8];
			nz_w[c]  = |chunk_w;
			lz_w[c]  = '0;
			for (int b = 0; b < 8; b++) begin
				if (chunk_w[b]) begin
					lz_w[c] = 3'(7 - b);
				end
			end
		end
		lzc_w = 7'(MAG_W);
		for (int c = NCH - 1; c >= 0; c--) begin
			if (nz_s1[c]) begin
				lzc_w = 7'(8 * c) + 7'(lz_s1[c]);
			end
		end
		zero_w = ~|nz_s1;
		if (lzc_s2 >= 7'(NORM_TOP)) begin
			ysh_w = y_s2 << (lzc_s2 - 7'(NORM_TOP));
			xsh_w = x_s2 << (lzc_s2 - 7'(NORM_TOP));
		end else begin
			ysh_w = y_s2 >> (7'(NORM_TOP) - lzc_s2);
			xsh_w = x_s2 >> (7'(NORM_TOP) - lzc_s2);
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			logic signed [CW-1:0] xi, yi;
			logic signed [Z_W-1:0] zi;
			if (i == 0) begin
				xi = CW'(x_s3);
				yi = CW'(y_s3);
				zi = '0;
			end else begin
				xi = cx_s[(i == 0) ? 0 : i-1];
				yi = cy_s[(i == 0) ? 0 : i-1];
				zi = cz_s[(i == 0) ? 0 : i-1];
			end
			if (yi >= 0) begin
				sx_w[i] = xi + (yi >>> i);
				sy_w[i] = yi - (xi >>> i);
				sz_w[i] = zi + atan_tab(5'(i));
			end else begin
				sx_w[i] = xi - (yi >>> i);
				sy_w[i] = yi + (xi >>> i);
				sz_w[i] = zi - atan_tab(5'(i));
			end
		end
	end

	always_comb begin
		if (cz_s[N-1] < 0) begin
			zc_w = '0;
		end else if (cz_s[N-1] > Z_W'(Z_MAX)) begin
			zc_w = Z_W'(Z_MAX);
		end else begin
			zc_w = cz_s[N-1];
		end
		zr_w = (zc_w + Z_W'(1 << (ANG_FRAC - 1))) >>> ANG_FRAC;
		q_w  = zr_w[14:0];
		case (sg_s[N-1][1:0])
			2'b00: a_w = 17'(q_w);
			2'b10: a_w = 17'(ANG_HALF) - 17'(q_w);
			2'b11: a_w = 17'(ANG_HALF) + 17'(q_w);
			2'b01: a_w = 17'(ANG_FULL) - 17'(q_w);
			default: a_w = '0;
		endcase
		if (a_w >= 17'(ANG_FULL) || sg_s[N-1][2]) begin
			a_w = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			cvld_s <= '0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			cvld_s <= {cvld_s[N-2:0], vld_s3};
			vld_s5 <= cvld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1    <= in_y;
			x_s1    <= in_x;
			sg_s1   <= {1'b0, in_nx, in_ny};
			side_s1 <= in_side;
			nz_s1   <= nz_w;
			for (int c = 0; c < NCH; c++) begin
				lz_s1[c] <= lz_w[c];
			end
			y_s2    <= y_s1;
			x_s2    <= x_s1;
			lzc_s2  <= lzc_w;
			sg_s2   <= {zero_w, sg_s1[1:0]};
			side_s2 <= side_s1;
			y_s3    <= ysh_w[29:0];
			x_s3    <= xsh_w[29:0];
			sg_s3   <= sg_s2;
			side_s3 <= side_s2;
			sg_s[0]    <= sg_s3;
			cside_s[0] <= side_s3;
			for (int i = 0; i < N; i++) begin
				cx_s[i] <= sx_w[i];
				cy_s[i] <= sy_w[i];
				cz_s[i] <= sz_w[i];
			end
			for (int i = 1; i < N; i++) begin
				sg_s[i]    <= sg_s[i-1];
				cside_s[i] <= cside_s[i-1];
			end
			ang_s5  <= a_w[ANG_W-1:0];
			side_s5 <= cside_s[N-1];
		end
	end

	assign out_vld  = vld_s5;
	assign out_ang  = ang_s5;
	assign out_side = side_s5;

endmodule

[hw/rtl/ofgm_back.sv]
// Back pipeline: square roots, yaw product, three arctangent units, output register.
// Depends on ofgm_pkg, ofgm_isqrt and ofgm_atan.
module ofgm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  ofgm_pkg::item_t      in_item,
	output logic                 in_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [47:0]          out_data,
	output logic                 out_flag
);
	import ofgm_pkg::*;

	typedef struct packed {
		logic               ok;
		logic               hy_neg;
		logic [31:0]        hy_mag;
		logic               my_neg;
		logic [47:0]        my_mag;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		logic signed [16:0] t;
		t = v[15] ? -17'(v) : 17'(v);
		return t[15:0];
	endfunction

	logic en;
	logic vld_s1, vld_s2, vld_q;
	side_t side_s1, side_a;
	logic signed [32:0] hy_abs_w;
	logic signed [49:0] my_abs_w;
	logic [31:0] asq_s1, axz_s1;
	logic vld_a, vld_b, ok_b;
	logic [ISQ_IN_W/2-1:0] sa_w, sb_w;
	logic [62:0] yy_w;
	logic [MAG_W-1:0] yy_s2, yx_s2, py_s2, px_s2, ry_s2, rx_s2;
	logic yny_s2, ynx_s2, pny_s2, rny_s2, rnx_s2, ok_s2;
	logic vy, vp, vr, oky, okp, okr;
	logic [ANG_W-1:0] ang_y, ang_p, ang_r;
	logic [47:0] data_q;
	logic flag_q;

	always_comb begin
		en       = !vld_q || out_ready;
		in_pop   = en && in_valid;
		hy_abs_w = in_item.hy[32] ? -in_item.hy : in_item.hy;
		my_abs_w = in_item.my[49] ? -in_item.my : in_item.my;
		yy_w     = side_a.hy_mag * sa_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_a && vld_b;
			vld_q  <= vy && vp && vr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.ok     <= in_item.ok;
			side_s1.hy_neg <= in_item.hy[32];
			side_s1.hy_mag <= hy_abs_w[31:0];
			side_s1.my_neg <= in_item.my[49];
			side_s1.my_mag <= my_abs_w[47:0];
			side_s1.ax     <= in_item.ax;
			side_s1.ay     <= in_item.ay;
			side_s1.az     <= in_item.az;
			asq_s1         <= in_item.asq;
			axz_s1         <= in_item.axz;
			yy_s2  <= MAG_W'(yy_w);
			yx_s2  <= {1'b0, side_a.my_mag, 15'd0};
			yny_s2 <= side_a.hy_neg;
			ynx_s2 <= side_a.my_neg;
			py_s2  <= {34'd0, abs16(side_a.ay), 14'd0};
			pny_s2 <= side_a.ay > 16'sd0;
			px_s2  <= MAG_W'(sb_w);
			ry_s2  <= MAG_W'(abs16(side_a.ax));
			rny_s2 <= side_a.ax > 16'sd0;
			rx_s2  <= MAG_W'(abs16(side_a.az));
			rnx_s2 <= side_a.az[15];
			ok_s2  <= side_a.ok && ok_b;
			flag_q <= oky && okp && okr;
			data_q <= (oky && okp && okr) ? {ang_r, ang_p, ang_y} : 48'd0;
		end
	end

	ofgm_isqrt #(.IN_W(ISQ_IN_W), .SIDE_W(SIDE_W)) u_isqrt_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.in_val({asq_s1, 30'd0}), .in_side(side_s1),
		.out_vld(vld_a), .out_root(sa_w), .out_side(side_a)
	);

	ofgm_isqrt #(.IN_W(ISQ_IN_W), .SIDE_W(1)) u_isqrt_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.in_val({2'd0, axz_s1, 28'd0}), .in_side(side_s1.ok),
		.out_vld(vld_b), .out_root(sb_w), .out_side(ok_b)
	);

	ofgm_atan #(.SIDE_W(1)) u_atan_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.in_y(yy_s2), .in_ny(yny_s2), .in_x(yx_s2), .in_nx(ynx_s2), .in_side(ok_s2),
		.out_vld(vy), .out_ang(ang_y), .out_side(oky)
	);

	ofgm_atan #(.SIDE_W(1)) u_atan_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.in_y(py_s2), .in_ny(pny_s2), .in_x(px_s2), .in_nx(1'b0), .in_side(ok_s2),
		.out_vld(vp), .out_ang(ang_p), .out_side(okp)
	);

	ofgm_atan #(.SIDE_W(1)) u_atan_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.in_y(ry_s2), .in_ny(rny_s2), .in_x(rx_s2), .in_nx(rnx_s2), .in_side(ok_s2),
		.out_vld(vr), .out_ang(ang_r), .out_side(okr)
	);

	assign out_valid = vld_q;
	assign out_data  = data_q;
	assign out_flag  = flag_q;

endmodule

[hw/rtl/orientation_from_gravity_mag.sv]
// Yaw, pitch and roll in centidegrees from one gravity and one magnetic vector.
// Throughput: one item per cycle when not stalled; the front, the 4-entry queue and the back stall separately.
// Reset: arst_n clears all valid flags and loads min_cross_norm with 1.
// Depends on ofgm_pkg, ofgm_front, ofgm_queue and ofgm_back.
module orientation_from_gravity_mag #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // grav_x, grav_y, grav_z, field_x, field_y, field_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // yaw_centideg, pitch_centideg, roll_centideg
	output logic [0:0]  m_tuser,   // angles_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // min_cross_norm
);
	import ofgm_pkg::*;

	logic f_valid, q_full, q_valid, q_pop;
	item_t f_item, q_item;

	assign cfg_ready = 1'b1;

	ofgm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.out_valid(f_valid), .out_full(q_full), .out_item(f_item)
	);

	ofgm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_full(q_full), .push_item(f_item),
		.pop(q_pop), .head_valid(q_valid), .head_item(q_item)
	);

	ofgm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_item(q_item), .in_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_data(m_tdata), .out_flag(m_tuser[0])
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 48'd0)
		else $error("invalid item carries nonzero angles");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] < 16'(ANG_FULL) && m_tdata[31:16] < 16'(ANG_FULL)
			&& m_tdata[47:32] < 16'(ANG_FULL))
		else $error("angle out of range");

endmodule
